>>> src/skva_pkg.sv
// ----------------------------------------------------------------------------
// skva_pkg
// Shared sizes, beat types, status codes and the saturating adder for the
// sorted key/value accumulator.
// ----------------------------------------------------------------------------
package skva_pkg;

    // store geometry
    localparam int CAPACITY   = 32;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int LIMIT_W    = 6;
    localparam int TOTAL_W    = 6;
    localparam int STATUS_W   = 3;

    // command codes
    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ACCUMULATED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DRAINED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd4;

    // input beat
    typedef struct packed {
        logic                         cmd;
        logic [KEY_BITS-1:0]          entry_key;
        logic signed [VALUE_BITS-1:0] entry_value;
    } t_item;

    // result beat
    typedef struct packed {
        logic [STATUS_W-1:0]          status;
        logic [KEY_BITS-1:0]          out_key;
        logic signed [VALUE_BITS-1:0] out_value;
        logic [TOTAL_W-1:0]           entry_total;
        logic                         last;
    } t_result;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic cmp;      // latch compare flags and candidate sum
        logic ins;      // insert: open a slot and shift larger keys up
        logic acc;      // accumulate into the matching cell
        logic shift_dn; // drain: every cell takes its upper neighbor
    } t_cell_ctl;

    // saturating add of two Q16.16 values
    function automatic logic signed [VALUE_BITS-1:0] sat_add(
        input logic signed [VALUE_BITS-1:0] a,
        input logic signed [VALUE_BITS-1:0] b
    );
        logic signed [VALUE_BITS:0]   s;
        logic signed [VALUE_BITS-1:0] r;
        s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
        if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
            r = s[VALUE_BITS] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                              : {1'b0, {(VALUE_BITS-1){1'b1}}};
        end else begin
            r = s[VALUE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

>>> src/skva_cell.sv
// ----------------------------------------------------------------------------
// skva_cell
// One slot of the sorted store: holds a key/value pair, compares it against
// the broadcast key and takes data from a neighbor on insert or drain.
// ----------------------------------------------------------------------------
module skva_cell (
    input  logic                                 i_clk,
    input  skva_pkg::t_cell_ctl                  i_ctl,
    input  logic                                 i_valid,     // slot below count
    input  logic                                 i_at_count,  // first free slot
    input  logic [skva_pkg::KEY_BITS-1:0]        i_key,
    input  logic signed [skva_pkg::VALUE_BITS-1:0] i_value,
    input  logic                                 i_prev_gt,
    input  logic [skva_pkg::KEY_BITS-1:0]        i_prev_key,
    input  logic signed [skva_pkg::VALUE_BITS-1:0] i_prev_value,
    input  logic [skva_pkg::KEY_BITS-1:0]        i_next_key,
    input  logic signed [skva_pkg::VALUE_BITS-1:0] i_next_value,
    output logic [skva_pkg::KEY_BITS-1:0]        o_key,
    output logic signed [skva_pkg::VALUE_BITS-1:0] o_value,
    output logic                                 o_gt,
    output logic                                 o_eq,
    output logic signed [skva_pkg::VALUE_BITS-1:0] o_sum
);
    import skva_pkg::*;

    logic [KEY_BITS-1:0]          r_key,   n_key;
    logic signed [VALUE_BITS-1:0] r_value, n_value;
    logic                         r_gt;
    logic                         r_eq;
    logic signed [VALUE_BITS-1:0] r_sum;

    // compare stage: flags and candidate sum
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_eq  <= i_valid && (r_key == i_key);
            r_gt  <= i_valid && (r_key > i_key);
            r_sum <= sat_add(r_value, i_value);
        end
    end

    // slot update
    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        if (i_ctl.shift_dn) begin
            n_key   = i_next_key;
            n_value = i_next_value;
        end else if (i_ctl.ins && ((i_valid && r_gt) || i_at_count)) begin
            if (i_prev_gt) begin
                n_key   = i_prev_key;
                n_value = i_prev_value;
            end else begin
                n_key   = i_key;
                n_value = i_value;
            end
        end else if (i_ctl.acc && r_eq) begin
            n_value = r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_gt    = r_gt;
    assign o_eq    = r_eq;
    assign o_sum   = r_sum;

endmodule

>>> src/sorted_key_value_accumulator.sv
// ----------------------------------------------------------------------------
// sorted_key_value_accumulator
// Row accumulator for sparse products: a chain of cells keeps key/value
// pairs sorted by key, merges equal keys and drains in key order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall, payload t_item) takes one beat
//   per item. cmd = accumulate adds entry_value to the cell holding
//   entry_key, or inserts the pair in sorted place, or drops it when the
//   store is full; one status beat results. cmd = drain sends every stored
//   pair in key order (last marks the final one) and empties the store; an
//   empty store gives one status beat. Output channel (o_out_valid /
//   i_out_stall, payload t_result) is fed from one output register.
//   An accumulate item passes through accept, compare (in all cells in
//   parallel) and update; its result beat is registered by the update step,
//   and the next item can be taken in the same cycle as that beat is valid,
//   so a new item is not taken before the last one is through. A drain sends
//   one beat per cycle while the receiver does not stall, as the cell chain
//   shifts down toward slot 0. The capacity register (i_cfg_we / i_cfg_data)
//   must be written only while the block is idle, which the block itself
//   does not enforce. Values above the cell count act as the cell count.
//   Reset empties the store and sets the capacity to the cell count. While
//   the receiver stalls, the pending beat holds and the sequencer waits; no beat is lost.
// ----------------------------------------------------------------------------
module sorted_key_value_accumulator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [skva_pkg::LIMIT_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  skva_pkg::t_item               i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output skva_pkg::t_result             o_out_data
);
    import skva_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CMP   = 4'b0010,
        S_EXEC  = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    t_item               r_item;
    logic [LIMIT_W-1:0]  r_cap;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_left,  n_left;
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;

    t_cell_ctl           w_ctl;
    logic [CNT_W-1:0]    w_limit;
    logic                w_out_free;
    logic                w_match;
    logic signed [VALUE_BITS-1:0] w_match_sum;

    logic [KEY_BITS-1:0]          w_key   [CAPACITY];
    logic signed [VALUE_BITS-1:0] w_value [CAPACITY];
    logic signed [VALUE_BITS-1:0] w_sum   [CAPACITY];
    logic [CAPACITY-1:0]          w_gt;
    logic [CAPACITY-1:0]          w_eq;

    // effective capacity: register clipped to the cell count
    assign w_limit = ({1'b0, r_cap} > (LIMIT_W+1)'(CAPACITY)) ? CNT_W'(CAPACITY)
                                                              : CNT_W'(r_cap);

    assign w_out_free = !r_out_valid || !i_out_stall;

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                         w_prev_gt;
        logic [KEY_BITS-1:0]          w_prev_key;
        logic signed [VALUE_BITS-1:0] w_prev_value;
        logic [KEY_BITS-1:0]          w_next_key;
        logic signed [VALUE_BITS-1:0] w_next_value;

        if (i == 0) begin : g_first
            assign w_prev_gt    = 1'b0;
            assign w_prev_key   = '0;
            assign w_prev_value = '0;
        end else begin : g_mid
            assign w_prev_gt    = w_gt[i-1];
            assign w_prev_key   = w_key[i-1];
            assign w_prev_value = w_value[i-1];
        end

        if (i == CAPACITY - 1) begin : g_top
            assign w_next_key   = '0;
            assign w_next_value = '0;
        end else begin : g_low
            assign w_next_key   = w_key[i+1];
            assign w_next_value = w_value[i+1];
        end

        skva_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_valid      (CNT_W'(i) < r_count),
            .i_at_count   (CNT_W'(i) == r_count),
            .i_key        (r_item.entry_key),
            .i_value      (r_item.entry_value),
            .i_prev_gt    (w_prev_gt),
            .i_prev_key   (w_prev_key),
            .i_prev_value (w_prev_value),
            .i_next_key   (w_next_key),
            .i_next_value (w_next_value),
            .o_key        (w_key[i]),
            .o_value      (w_value[i]),
            .o_gt         (w_gt[i]),
            .o_eq         (w_eq[i]),
            .o_sum        (w_sum[i])
        );
    end

    // pick the sum of the single matching cell
    always_comb begin
        w_match_sum = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (w_eq[k]) begin
                w_match_sum = w_match_sum | w_sum[k];
            end
        end
    end
    assign w_match = |w_eq;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_ctl       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                w_ctl.cmp = 1'b1;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                if (r_item.cmd == CMD_DRAIN) begin
                    if (r_count == '0) begin
                        if (w_out_free) begin
                            n_out_valid       = 1'b1;
                            n_out.status      = ST_EMPTY;
                            n_out.out_key     = r_item.entry_key;
                            n_out.out_value   = '0;
                            n_out.entry_total = '0;
                            n_out.last        = 1'b1;
                            n_state           = S_IDLE;
                        end
                    end else begin
                        n_left  = r_count;
                        n_state = S_DRAIN;
                    end
                end else if (w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.out_key     = r_item.entry_key;
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                    if (w_match) begin
                        w_ctl.acc         = 1'b1;
                        n_out.status      = ST_ACCUMULATED;
                        n_out.out_value   = w_match_sum;
                        n_out.entry_total = TOTAL_W'(r_count);
                    end else if (r_count < w_limit) begin
                        w_ctl.ins         = 1'b1;
                        n_count           = r_count + CNT_W'(1);
                        n_out.status      = ST_INSERTED;
                        n_out.out_value   = r_item.entry_value;
                        n_out.entry_total = TOTAL_W'(n_count);
                    end else begin
                        n_out.status      = ST_DROPPED;
                        n_out.out_value   = '0;
                        n_out.entry_total = TOTAL_W'(r_count);
                    end
                end
            end
            S_DRAIN: begin
                if (w_out_free) begin
                    w_ctl.shift_dn    = 1'b1;
                    n_out_valid       = 1'b1;
                    n_out.status      = ST_DRAINED;
                    n_out.out_key     = w_key[0];
                    n_out.out_value   = w_value[0];
                    n_out.entry_total = TOTAL_W'(r_count);
                    n_out.last        = (r_left == CNT_W'(1));
                    n_left            = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
            r_cap       <= LIMIT_W'(CAPACITY);
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_state == S_IDLE && i_in_valid) begin
            r_item <= i_in_data;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
